// ===== rtl/cic_pkg.sv =====
package cic_pkg;

	localparam int COUNT_WIDTH    = 32;
	localparam int FRACTION_BITS  = 16;
	localparam int TOTAL_WIDTH    = COUNT_WIDTH + 2;
	localparam int REM_WIDTH      = TOTAL_WIDTH + 1;
	localparam int RATIO_WIDTH    = 17;
	localparam int STEP_WIDTH     = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;
	localparam int THRESH_WIDTH   = 16;
	localparam int CHAR_WIDTH     = 8;

	localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(10);
	localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX    = {COUNT_WIDTH{1'b1}};
	localparam logic [STEP_WIDTH-1:0]   STEP_LAST    = STEP_WIDTH'(FRACTION_BITS - 1);

	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CHAR_M     = 8'h4D;
	localparam logic [CHAR_WIDTH-1:0] CHAR_EQ    = 8'h3D;
	localparam logic [CHAR_WIDTH-1:0] CHAR_X     = 8'h58;
	localparam logic [CHAR_WIDTH-1:0] CHAR_I     = 8'h49;
	localparam logic [CHAR_WIDTH-1:0] CHAR_D     = 8'h44;
	localparam logic [CHAR_WIDTH-1:0] CHAR_N     = 8'h4E;
	localparam logic [CHAR_WIDTH-1:0] CHAR_S     = 8'h53;
	localparam logic [CHAR_WIDTH-1:0] CHAR_H     = 8'h48;
	localparam logic [CHAR_WIDTH-1:0] CHAR_P     = 8'h50;

	typedef struct packed {
		logic char_en;
		logic capture;
		logic gap;
		logic div_init;
		logic div_step;
		logic result_load;
	} cic_cmd_t;

	typedef struct packed {
		logic result_busy;
	} cic_status_t;

endpackage

// ===== rtl/cic_ctrl.sv =====
module cic_ctrl
	import cic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_last,
	output logic        in_ready,
	input  cic_status_t status,
	output cic_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TOT  = 3'd1;
	localparam logic [2:0] ST_GAP  = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]            state_q;
	logic [2:0]            state_next;
	logic [STEP_WIDTH-1:0] step_q;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.char_en = 1'b1;
					if (in_last) begin
						state_next = ST_TOT;
					end
				end
			end
			ST_TOT: begin
				cmd.capture = 1'b1;
				state_next  = ST_GAP;
			end
			ST_GAP: begin
				cmd.gap    = 1'b1;
				state_next = ST_INIT;
			end
			ST_INIT: begin
				cmd.div_init = 1'b1;
				state_next   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_LAST) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.result_busy) begin
					cmd.result_load = 1'b1;
					state_next      = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (cmd.div_init) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_WIDTH'(1);
			end
		end
	end

endmodule

// ===== rtl/cic_dp.sv =====
module cic_dp
	import cic_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cic_cmd_t                cmd,
	output cic_status_t             status,
	input  logic [CHAR_WIDTH-1:0]   char_byte,
	input  logic                    thresh_wr_en,
	input  logic [THRESH_WIDTH-1:0] thresh_wr_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [RATIO_WIDTH-1:0]  identity,
	output logic [RATIO_WIDTH-1:0]  identity_no_long_gaps,
	output logic                    saturated
);

	logic [THRESH_WIDTH-1:0] thresh_q;
	logic [COUNT_WIDTH-1:0]  run_q;
	logic                    have_digits_q;
	logic [COUNT_WIDTH-1:0]  match_q;
	logic [COUNT_WIDTH-1:0]  mismatch_q;
	logic [COUNT_WIDTH-1:0]  insert_q;
	logic [COUNT_WIDTH-1:0]  delete_q;
	logic [COUNT_WIDTH-1:0]  long_q;
	logic                    ovf_q;

	logic [TOTAL_WIDTH-1:0]  total_q;
	logic [TOTAL_WIDTH-1:0]  short_q;
	logic [COUNT_WIDTH-1:0]  num_q;
	logic [COUNT_WIDTH-1:0]  long_cap_q;
	logic                    sat_cap_q;

	logic [REM_WIDTH-1:0]     rem_a_q;
	logic [REM_WIDTH-1:0]     rem_b_q;
	logic [FRACTION_BITS-1:0] quot_a_q;
	logic [FRACTION_BITS-1:0] quot_b_q;
	logic                     zero_a_q;
	logic                     zero_b_q;
	logic                     full_a_q;
	logic                     full_b_q;

	logic                   out_valid_q;
	logic [RATIO_WIDTH-1:0] ident_q;
	logic [RATIO_WIDTH-1:0] ident_ng_q;
	logic                   sat_out_q;

	logic                   is_digit;
	logic [3:0]             digit;
	logic [COUNT_WIDTH+3:0] run_x10;
	logic                   run_ovf;
	logic                   is_op;
	logic                   apply;
	logic                   is_long;
	logic [COUNT_WIDTH:0]   add_match;
	logic [COUNT_WIDTH:0]   add_mismatch;
	logic [COUNT_WIDTH:0]   add_insert;
	logic [COUNT_WIDTH:0]   add_delete;
	logic [COUNT_WIDTH:0]   add_long;
	logic [TOTAL_WIDTH-1:0] long_ext;
	logic [TOTAL_WIDTH-1:0] num_ext;
	logic [REM_WIDTH-1:0]   rem_a_sh;
	logic [REM_WIDTH-1:0]   rem_b_sh;
	logic                   ge_a;
	logic                   ge_b;

	always_comb begin
		is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
		digit    = 4'(char_byte - CHAR_ZERO);
		run_x10  = {1'b0, run_q, 3'b000} + {3'b000, run_q, 1'b0}
		         + {{COUNT_WIDTH{1'b0}}, digit};
		run_ovf  = |run_x10[COUNT_WIDTH+3:COUNT_WIDTH];
		is_op    = (char_byte == CHAR_M) || (char_byte == CHAR_EQ) || (char_byte == CHAR_X)
		        || (char_byte == CHAR_I) || (char_byte == CHAR_D) || (char_byte == CHAR_N)
		        || (char_byte == CHAR_S) || (char_byte == CHAR_H) || (char_byte == CHAR_P);
		apply    = cmd.char_en && !is_digit && is_op && have_digits_q;
		is_long  = run_q >= {{(COUNT_WIDTH-THRESH_WIDTH){1'b0}}, thresh_q};

		add_match    = {1'b0, match_q} + {1'b0, run_q};
		add_mismatch = {1'b0, mismatch_q} + {1'b0, run_q};
		add_insert   = {1'b0, insert_q} + {1'b0, run_q};
		add_delete   = {1'b0, delete_q} + {1'b0, run_q};
		add_long     = {1'b0, long_q} + {1'b0, run_q};

		long_ext = {2'b00, long_cap_q};
		num_ext  = {2'b00, num_q};

		rem_a_sh = {rem_a_q[REM_WIDTH-2:0], 1'b0};
		rem_b_sh = {rem_b_q[REM_WIDTH-2:0], 1'b0};
		ge_a     = rem_a_sh >= {1'b0, total_q};
		ge_b     = rem_b_sh >= {1'b0, short_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q      <= THRESH_RESET;
			run_q         <= '0;
			have_digits_q <= 1'b0;
			match_q       <= '0;
			mismatch_q    <= '0;
			insert_q      <= '0;
			delete_q      <= '0;
			long_q        <= '0;
			ovf_q         <= 1'b0;
		end else begin
			if (thresh_wr_en) begin
				thresh_q <= thresh_wr_data;
			end
			if (cmd.capture) begin
				run_q         <= '0;
				have_digits_q <= 1'b0;
				match_q       <= '0;
				mismatch_q    <= '0;
				insert_q      <= '0;
				delete_q      <= '0;
				long_q        <= '0;
				ovf_q         <= 1'b0;
			end else if (cmd.char_en) begin
				if (is_digit) begin
					have_digits_q <= 1'b1;
					if (run_ovf) begin
						run_q <= COUNT_MAX;
						ovf_q <= 1'b1;
					end else begin
						run_q <= run_x10[COUNT_WIDTH-1:0];
					end
				end else begin
					run_q         <= '0;
					have_digits_q <= 1'b0;
				end
				if (apply) begin
					if ((char_byte == CHAR_M) || (char_byte == CHAR_EQ)) begin
						match_q <= add_match[COUNT_WIDTH] ? COUNT_MAX
						                                  : add_match[COUNT_WIDTH-1:0];
						if (add_match[COUNT_WIDTH]) begin
							ovf_q <= 1'b1;
						end
					end
					if (char_byte == CHAR_X) begin
						mismatch_q <= add_mismatch[COUNT_WIDTH] ? COUNT_MAX
						                                        : add_mismatch[COUNT_WIDTH-1:0];
						if (add_mismatch[COUNT_WIDTH]) begin
							ovf_q <= 1'b1;
						end
					end
					if (char_byte == CHAR_I) begin
						insert_q <= add_insert[COUNT_WIDTH] ? COUNT_MAX
						                                    : add_insert[COUNT_WIDTH-1:0];
						if (add_insert[COUNT_WIDTH]) begin
							ovf_q <= 1'b1;
						end
					end
					if (char_byte == CHAR_D) begin
						delete_q <= add_delete[COUNT_WIDTH] ? COUNT_MAX
						                                    : add_delete[COUNT_WIDTH-1:0];
						if (add_delete[COUNT_WIDTH]) begin
							ovf_q <= 1'b1;
						end
					end
					if (((char_byte == CHAR_I) || (char_byte == CHAR_D)) && is_long) begin
						long_q <= add_long[COUNT_WIDTH] ? COUNT_MAX : add_long[COUNT_WIDTH-1:0];
						if (add_long[COUNT_WIDTH]) begin
							ovf_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			total_q    <= {2'b00, match_q} + {2'b00, mismatch_q}
			            + {2'b00, insert_q} + {2'b00, delete_q};
			num_q      <= match_q;
			long_cap_q <= long_q;
			sat_cap_q  <= ovf_q;
		end
		if (cmd.gap) begin
			short_q <= (long_ext > total_q) ? '0 : total_q - long_ext;
		end
		if (cmd.div_init) begin
			rem_a_q  <= {3'b000, num_q};
			rem_b_q  <= {3'b000, num_q};
			quot_a_q <= '0;
			quot_b_q <= '0;
			zero_a_q <= total_q == '0;
			zero_b_q <= short_q == '0;
			full_a_q <= num_ext >= total_q;
			full_b_q <= num_ext >= short_q;
		end else if (cmd.div_step) begin
			rem_a_q  <= ge_a ? rem_a_sh - {1'b0, total_q} : rem_a_sh;
			rem_b_q  <= ge_b ? rem_b_sh - {1'b0, short_q} : rem_b_sh;
			quot_a_q <= {quot_a_q[FRACTION_BITS-2:0], ge_a};
			quot_b_q <= {quot_b_q[FRACTION_BITS-2:0], ge_b};
		end
		if (cmd.result_load) begin
			ident_q    <= zero_a_q ? '0
			            : full_a_q ? RATIO_WIDTH'(1 << FRACTION_BITS)
			            : RATIO_WIDTH'(quot_a_q);
			ident_ng_q <= zero_b_q ? '0
			            : full_b_q ? RATIO_WIDTH'(1 << FRACTION_BITS)
			            : RATIO_WIDTH'(quot_b_q);
			sat_out_q  <= sat_cap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.result_busy    = out_valid_q;
	assign out_valid             = out_valid_q;
	assign identity              = ident_q;
	assign identity_no_long_gaps = ident_ng_q;
	assign saturated             = sat_out_q;

endmodule

// ===== rtl/cigar_identity_calculator_unit.sv =====
// A result word follows the last word through the total, gap, init, divide and done states.
// Throughput: one character word per cycle; after a last word the input is held off for
// the totals, the bit-serial divider and, if needed, until the previous result word has
// been taken.
// Reset: arst_n clears all counters and the controller at once and sets the gap
// threshold to 10; the block is ready as soon as reset is released.
module cigar_identity_calculator_unit
	import cic_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [7:0]              s_axis_tdata,  // char_byte
	input  logic                    s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [39:0]             m_axis_tdata,  // identity, identity_no_long_gaps, zero pad
	output logic                    m_axis_tuser,  // saturated
	input  logic                    gap_threshold_wr_en,
	input  logic [THRESH_WIDTH-1:0] gap_threshold_wr_data
);

	cic_cmd_t               cmd;
	cic_status_t            status;
	logic [RATIO_WIDTH-1:0] identity;
	logic [RATIO_WIDTH-1:0] identity_no_long_gaps;

	cic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cic_dp u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.status                (status),
		.char_byte             (s_axis_tdata),
		.thresh_wr_en          (gap_threshold_wr_en),
		.thresh_wr_data        (gap_threshold_wr_data),
		.out_valid             (m_axis_tvalid),
		.out_ready             (m_axis_tready),
		.identity              (identity),
		.identity_no_long_gaps (identity_no_long_gaps),
		.saturated             (m_axis_tuser)
	);

	assign m_axis_tdata = {6'b000000, identity_no_long_gaps, identity};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cic_pkg::*;

	localparam logic [63:0] CMAX = 64'(COUNT_MAX);
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_CHARS = 100;
	localparam logic [7:0] OP_CHARS [9] = '{CHAR_M, CHAR_EQ, CHAR_X, CHAR_I, CHAR_D,
		CHAR_N, CHAR_S, CHAR_H, CHAR_P};

	typedef struct packed {
		logic [RATIO_WIDTH-1:0] identity;
		logic [RATIO_WIDTH-1:0] identity_short;
		logic                   saturated;
	} identity_word_t;

	class cigar_tally;
		logic [THRESH_WIDTH-1:0] threshold;
		logic [63:0]             run_len;
		bit                      digits;
		logic [63:0]             match_total;
		logic [63:0]             mismatches;
		logic [63:0]             inserts;
		logic [63:0]             deletes;
		logic [63:0]             gap_excess;
		bit                      sat;
		identity_word_t          identity_due[$];
		int                      errors;

		function new();
			threshold = THRESH_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			run_len = 0;
			digits = 0;
			match_total = 0;
			mismatches = 0;
			inserts = 0;
			deletes = 0;
			gap_excess = 0;
			sat = 0;
		endfunction

		function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
			if (b > CMAX - a) begin
				sat = 1;
				return CMAX;
			end
			return a + b;
		endfunction

		function logic [RATIO_WIDTH-1:0] ratio(logic [63:0] num, logic [63:0] den);
			logic [63:0] q;
			logic [63:0] r;
			if (den == 0)
				return '0;
			if (num >= den)
				return RATIO_WIDTH'(64'd1 << FRACTION_BITS);
			q = 0;
			r = num;
			for (int k = 0; k < FRACTION_BITS; k++) begin
				r = r << 1;
				q = q << 1;
				if (r >= den) begin
					r = r - den;
					q[0] = 1'b1;
				end
			end
			return RATIO_WIDTH'(q);
		endfunction

		function void take_char(logic [7:0] c, logic l);
			logic [63:0]    d;
			logic [63:0]    total;
			logic [63:0]    short_total;
			identity_word_t w;
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = 64'(c - CHAR_ZERO);
				if (run_len > (CMAX - d) / 10) begin
					run_len = CMAX;
					sat = 1;
				end else begin
					run_len = run_len * 10 + d;
				end
				digits = 1;
			end else begin
				if (digits) begin
					case (c)
						CHAR_M, CHAR_EQ: match_total = add_sat(match_total, run_len);
						CHAR_X: mismatches = add_sat(mismatches, run_len);
						CHAR_I: begin
							inserts = add_sat(inserts, run_len);
							if (run_len >= 64'(threshold))
								gap_excess = add_sat(gap_excess, run_len);
						end
						CHAR_D: begin
							deletes = add_sat(deletes, run_len);
							if (run_len >= 64'(threshold))
								gap_excess = add_sat(gap_excess, run_len);
						end
						default: ;
					endcase
				end
				run_len = 0;
				digits = 0;
			end
			if (l) begin
				total = match_total + mismatches + inserts + deletes;
				short_total = (gap_excess > total) ? 64'd0 : total - gap_excess;
				w.identity = ratio(match_total, total);
				w.identity_short = ratio(match_total, short_total);
				w.saturated = sat;
				identity_due.push_back(w);
				clear();
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_identity(logic [39:0] data, logic user);
			identity_word_t want;
			if (identity_due.size() == 0) begin
				report("result word with none expected");
				return;
			end
			want = identity_due.pop_front();
			if (data[RATIO_WIDTH-1:0] != want.identity)
				report($sformatf("identity %0d, expected %0d",
					data[RATIO_WIDTH-1:0], want.identity));
			if (data[2*RATIO_WIDTH-1:RATIO_WIDTH] != want.identity_short)
				report($sformatf("identity without long gaps %0d, expected %0d",
					data[2*RATIO_WIDTH-1:RATIO_WIDTH], want.identity_short));
			if (user != want.saturated)
				report($sformatf("saturated %0b, expected %0b", user, want.saturated));
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [7:0]              s_axis_tdata = '0;
	logic                    s_axis_tlast = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [39:0]             m_axis_tdata;
	logic                    m_axis_tuser;
	logic                    gap_threshold_wr_en = 1'b0;
	logic [THRESH_WIDTH-1:0] gap_threshold_wr_data = '0;

	cigar_tally              sb;
	bit                      calm = 1'b0;
	int                      chars_sent = 0;
	logic [7:0]              cigar_chars[$];
	logic [THRESH_WIDTH-1:0] phase_threshold [5];

	cigar_identity_calculator_unit i_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.s_axis_tvalid         (s_axis_tvalid),
		.s_axis_tready         (s_axis_tready),
		.s_axis_tdata          (s_axis_tdata),
		.s_axis_tlast          (s_axis_tlast),
		.m_axis_tvalid         (m_axis_tvalid),
		.m_axis_tready         (m_axis_tready),
		.m_axis_tdata          (m_axis_tdata),
		.m_axis_tuser          (m_axis_tuser),
		.gap_threshold_wr_en   (gap_threshold_wr_en),
		.gap_threshold_wr_data (gap_threshold_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_identity(m_axis_tdata, m_axis_tuser);
		m_axis_tready <= calm || ($urandom_range(99) >= 37);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: errors");
		$finish;
	end

	task automatic send_char(input logic [7:0] c, input logic l);
		while (!calm && $urandom_range(99) < 37) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= l;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.take_char(c, l);
		chars_sent++;
	endtask

	task automatic send_cigar();
		for (int k = 0; k < cigar_chars.size(); k++)
			send_char(cigar_chars[k], k == cigar_chars.size() - 1);
		cigar_chars.delete();
	endtask

	task automatic push_text(input string s);
		for (int k = 0; k < s.len(); k++)
			cigar_chars.push_back(s[k]);
	endtask

	task automatic push_length(input logic [THRESH_WIDTH-1:0] thr);
		logic [63:0] len;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			len = 64'($urandom_range(20));
		end else if (pick < 70) begin
			len = 64'(thr) + 64'($urandom_range(2));
			len = (len == 0) ? 64'd0 : len - 1;
		end else if (pick < 85) begin
			len = 64'($urandom_range(65535));
		end else if (pick < 93) begin
			len = 64'($urandom);
		end else if (pick < 97) begin
			len = CMAX;
		end else begin
			len = 64'd99999999999;
		end
		if ($urandom_range(9) == 0)
			cigar_chars.push_back(CHAR_ZERO);
		push_text($sformatf("%0d", len));
	endtask

	task automatic build_cigar(input logic [THRESH_WIDTH-1:0] thr);
		int ops;
		int pick;
		ops = $urandom_range(1, 6);
		for (int k = 0; k < ops; k++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				cigar_chars.push_back(8'($urandom_range(255)));
			end else if (pick < 12) begin
				cigar_chars.push_back(OP_CHARS[$urandom_range(8)]);
			end else begin
				push_length(thr);
				if ($urandom_range(99) < 90)
					cigar_chars.push_back(OP_CHARS[$urandom_range(8)]);
				else
					cigar_chars.push_back(8'($urandom_range(8'h61, 8'h7A)));
			end
		end
		if ($urandom_range(9) == 0)
			push_length(thr);
	endtask

	task automatic wait_idle();
		while (sb.identity_due.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THRESH_WIDTH-1:0] v);
		gap_threshold_wr_en <= 1'b1;
		gap_threshold_wr_data <= v;
		@(posedge clk);
		gap_threshold_wr_en <= 1'b0;
		sb.threshold = v;
	endtask

	initial begin
		sb = new();
		phase_threshold = '{16'd1, 16'hFFFF, 16'd0, 16'd0, THRESH_RESET};
		phase_threshold[3] = THRESH_WIDTH'($urandom_range(1, 65535));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_text("X5m3M2S9");
		send_cigar();
		push_text("4=2X3I12D");
		send_cigar();
		push_text("99999999999M");
		send_cigar();
		push_text("4294967295M9M");
		send_cigar();

		for (int p = 0; p < 5; p++) begin
			s_axis_tvalid <= 1'b0;
			wait_idle();
			write_threshold(phase_threshold[p]);
			calm = (p == 2);
			while (chars_sent < 40 + PHASE_CHARS * (p + 1)) begin
				build_cigar(phase_threshold[p]);
				send_cigar();
			end
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		while (sb.identity_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
